// ===== rtl/uart_keyvalue_command_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key/value command parser.
// Concurrent checks, disabled while the active-high reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UART_KEYVALUE_COMMAND_PARSER_UNIT_ASSERT_SVH
`define UART_KEYVALUE_COMMAND_PARSER_UNIT_ASSERT_SVH

// The consequence holds in the same cycle as the antecedent.
`define UKVCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define UKVCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ukvcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ukvcp_pkg
// Types, constants and helpers shared by the key/value command parser.
// ----------------------------------------------------------------------------
package ukvcp_pkg;

   // Limits of the command and of a number run.
   localparam int MAX_LINE_CHARS   = 255;
   localparam int MAX_NUMBER_CHARS = 31;
   localparam int CHAR_CNT_W       = $clog2(MAX_LINE_CHARS + 1);
   localparam int NUM_CNT_W        = $clog2(MAX_NUMBER_CHARS + 1);
   localparam int MAX_FRAC_DIGITS  = 9;
   localparam int FRAC_DIG_W       = 4;

   // Field widths.
   localparam int IDLE_W   = 10;
   localparam int WIN_W    = 80;
   localparam int NUM_KEYS = 7;
   localparam int WHOLE_W  = 16;
   localparam int FRAC_W   = 30;
   localparam int DATA_W   = 32;
   localparam int TGT_W    = 2;

   // Fraction divider: stages and quotient bits per stage.
   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS   = 4;
   localparam int QUO_W      = DIV_STAGES * DIV_BITS;

   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 10'd50;

   // Item kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Result targets.
   localparam logic [TGT_W-1:0] TGT_SETPOINT = 2'd0;
   localparam logic [TGT_W-1:0] TGT_MIN      = 2'd1;
   localparam logic [TGT_W-1:0] TGT_MAX      = 2'd2;
   localparam logic [TGT_W-1:0] TGT_HEIGHT   = 2'd3;

   // Integer scan phases.
   localparam logic [1:0] IPH_BEFORE = 2'd0;
   localparam logic [1:0] IPH_DIGITS = 2'd1;
   localparam logic [1:0] IPH_DONE   = 2'd2;

   // Characters of interest.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Keys, last character in the low byte.
   localparam logic [71:0] KEY_SETPOINT   = "Setpoint:";
   localparam logic [79:0] KEY_SETPOINT_M = "Setpointm:";
   localparam logic [79:0] KEY_SETPOINT_X = "SetpointM:";
   localparam logic [23:0] KEY_SP         = "SP:";
   localparam logic [23:0] KEY_SM         = "Sm:";
   localparam logic [23:0] KEY_SX         = "SM:";
   localparam logic [55:0] KEY_ALTURA     = "Altura:";

   // Scan state of the token being collected.
   typedef struct packed {
      logic [WIN_W-1:0]      window;
      logic [NUM_KEYS-1:0]   flags;
      logic [DATA_W-1:0]     int_acc;
      logic [1:0]            int_phase;
      logic [NUM_CNT_W-1:0]  int_digits;
      logic [WHOLE_W-1:0]    whole;
      logic [FRAC_W-1:0]     frac;
      logic [FRAC_DIG_W-1:0] frac_digits;
      logic                  started;
      logic                  done;
      logic                  neg;
      logic                  point;
      logic                  stopped;
      logic [NUM_CNT_W-1:0]  run_len;
   } token_type;

   // One result on its way through the fraction divider.
   typedef struct packed {
      logic [TGT_W-1:0]   target;
      logic [DATA_W-1:0]  int_val;
      logic [WHOLE_W-1:0] whole;
      logic [FRAC_W-1:0]  rem;
      logic [FRAC_W-1:0]  pow;
      logic [QUO_W-1:0]   quo;
      logic               neg;
   } pipe_type;

   // Ten to the power of the fraction digit count.
   function automatic logic [FRAC_W-1:0] pow10(input logic [FRAC_DIG_W-1:0] n);
      logic [FRAC_W-1:0] p;
      unique case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/ukvcp_channels.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------

// Request channel: a received byte or a millisecond tick.
interface ukvcp_req_if import ukvcp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink (input valid, input kind, input byte_value, output ready);
endinterface

// Response channel: one updated parameter.
interface ukvcp_rsp_if import ukvcp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TGT_W-1:0]         target;
   logic [DATA_W-1:0]        int_value;
   logic signed [DATA_W-1:0] real_value;

   modport source (output valid, output target, output int_value, output real_value,
                   input ready);
   modport sink (input valid, input target, input int_value, input real_value,
                 output ready);
endinterface

// Control register write channel: the idle limit.
interface ukvcp_csr_if import ukvcp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDLE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/uart_keyvalue_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// uart_keyvalue_command_parser_unit
// Parses serial key/value commands into setpoint and Q16.16 parameter updates.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                              Transaction
//   req_ch    in         kind, byte_value                     one byte or tick
//   rsp_ch    out        target, int_value, real_value        one update
//   csr_ch    in         data (idle limit, 10 bits)           one register write
//
// A request transaction is taken in every cycle unless the output stalls; the
// scan state updates in that same cycle. A result passes from the entry
// register through the four-stage fraction divider to the output register
// once its token ends. Reset is synchronous and clears the scan state, the
// valid bits and the idle limit (to 50). While the response register holds a
// result that is not taken, the whole pipeline and req_ch.ready hold.
//
`include "uart_keyvalue_command_parser_unit_assert.svh"

module uart_keyvalue_command_parser_unit import ukvcp_pkg::*; (
   input logic       clock,
   input logic       reset,
   ukvcp_req_if.sink req_ch,
   ukvcp_rsp_if.source rsp_ch,
   ukvcp_csr_if.sink csr_ch
);

   // Feeds one text character into the token scan.
   function automatic token_type feed_tok(input token_type t, input logic [7:0] c);
      token_type           r;
      logic                digit;
      logic [7:0]          dsub;
      logic [3:0]          d;
      logic [DATA_W+3:0]   iv;
      logic [WHOLE_W+3:0]  wv;
      logic [NUM_KEYS-1:0] hit;
      r     = t;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      dsub  = c - CH_ZERO;
      d     = dsub[3:0];

      // Key search over the last characters.
      r.window = {t.window[WIN_W-9:0], c};
      hit[0]   = (r.window[71:0] == KEY_SETPOINT);
      hit[1]   = (r.window[79:0] == KEY_SETPOINT_M);
      hit[2]   = (r.window[79:0] == KEY_SETPOINT_X);
      hit[3]   = (r.window[23:0] == KEY_SP);
      hit[4]   = (r.window[23:0] == KEY_SM);
      hit[5]   = (r.window[23:0] == KEY_SX);
      hit[6]   = (r.window[55:0] == KEY_ALTURA);
      r.flags  = t.flags | hit;

      // First digit run as a saturated integer.
      if (t.int_phase != IPH_DONE) begin
         if (!digit) begin
            if (t.int_phase == IPH_DIGITS) begin
               r.int_phase = IPH_DONE;
            end
         end else begin
            r.int_phase  = IPH_DIGITS;
            iv           = ({4'b0, t.int_acc} << 3) + ({4'b0, t.int_acc} << 1)
                           + {{DATA_W{1'b0}}, d};
            r.int_acc    = (iv[DATA_W+3:DATA_W] != 4'b0) ? '1 : iv[DATA_W-1:0];
            r.int_digits = t.int_digits + 1'b1;
            if (r.int_digits >= NUM_CNT_W'(MAX_NUMBER_CHARS)) begin
               r.int_phase = IPH_DONE;
            end
         end
      end

      // First number run as whole and fraction parts.
      if (!t.done) begin
         if (!(digit || (c == CH_POINT) || ((c == CH_MINUS) && !t.started))) begin
            if (t.started) begin
               r.done = 1'b1;
            end
         end else begin
            r.started = 1'b1;
            r.run_len = t.run_len + 1'b1;
            if (!t.stopped) begin
               if (c == CH_MINUS) begin
                  r.neg = 1'b1;
               end else if (c == CH_POINT) begin
                  if (t.point) begin
                     r.stopped = 1'b1;
                  end else begin
                     r.point = 1'b1;
                  end
               end else if (!t.point) begin
                  wv      = ({4'b0, t.whole} << 3) + ({4'b0, t.whole} << 1)
                            + {{WHOLE_W{1'b0}}, d};
                  r.whole = (wv[WHOLE_W+3:WHOLE_W] != 4'b0) ? '1 : wv[WHOLE_W-1:0];
               end else if (t.frac_digits < FRAC_DIG_W'(MAX_FRAC_DIGITS)) begin
                  r.frac        = FRAC_W'({t.frac, 3'b0} + {2'b0, t.frac, 1'b0}
                                          + {{(FRAC_W-1){1'b0}}, d});
                  r.frac_digits = t.frac_digits + 1'b1;
               end
            end
            if (r.run_len >= NUM_CNT_W'(MAX_NUMBER_CHARS)) begin
               r.done = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Several quotient bits of the fraction division.
   function automatic pipe_type div_step(input pipe_type p);
      pipe_type          r;
      logic [FRAC_W:0]   r2;
      r = p;
      for (int i = 0; i < DIV_BITS; i++) begin
         r2 = {r.rem, 1'b0};
         if (r2 >= {1'b0, r.pow}) begin
            r.rem = FRAC_W'(r2 - {1'b0, r.pow});
            r.quo = {r.quo[QUO_W-2:0], 1'b1};
         end else begin
            r.rem = r2[FRAC_W-1:0];
            r.quo = {r.quo[QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Registers.
   logic [IDLE_W-1:0]     idle_limit_ff;
   logic [CHAR_CNT_W-1:0] char_count_ff, char_count_in;
   logic [IDLE_W-1:0]     idle_count_ff, idle_count_in;
   logic                  nul_seen_ff, nul_seen_in;
   token_type             tok_ff, tok_in;
   pipe_type              pipe_ff [0:DIV_STAGES];
   pipe_type              pipe_in [0:DIV_STAGES];
   logic [DIV_STAGES:0]   pv_ff;
   logic                  out_valid_ff;
   logic [TGT_W-1:0]      out_target_ff, out_target_in;
   logic [DATA_W-1:0]     out_int_ff;
   logic [DATA_W-1:0]     out_real_ff, out_real_in;

   logic                  adv;
   logic                  req_fire;
   logic                  csr_fire;
   logic                  finish_tok;
   logic                  cmd_end;
   logic                  emit;
   token_type             tok_src;
   logic [CHAR_CNT_W-1:0] char_inc;
   logic [TGT_W-1:0]      sel_target;

   // Handshakes: the pipeline moves unless a result waits at the output.
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign req_fire     = req_ch.valid && adv;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;
   assign char_inc     = char_count_ff + 1'b1;

   // Command and token bookkeeping for one transaction.
   always_comb begin
      char_count_in = char_count_ff;
      idle_count_in = idle_count_ff;
      nul_seen_in   = nul_seen_ff;
      tok_src       = tok_ff;
      finish_tok    = 1'b0;
      cmd_end       = 1'b0;
      if (req_fire) begin
         if (req_ch.kind == KIND_TICK) begin
            if (char_count_ff != '0) begin
               if (idle_count_ff >= idle_limit_ff) begin
                  cmd_end = 1'b1;
               end else begin
                  idle_count_in = idle_count_ff + 1'b1;
               end
            end
         end else begin
            idle_count_in = '0;
            if ((req_ch.byte_value == CH_CR) || (req_ch.byte_value == CH_LF)) begin
               if (char_count_ff != '0) begin
                  cmd_end = 1'b1;
               end
            end else begin
               char_count_in = char_inc;
               if (!nul_seen_ff) begin
                  if (req_ch.byte_value == CH_NUL) begin
                     nul_seen_in = 1'b1;
                  end else if (req_ch.byte_value == CH_COMMA) begin
                     finish_tok = 1'b1;
                  end else begin
                     tok_src = feed_tok(tok_ff, req_ch.byte_value);
                  end
               end
               if (char_inc >= CHAR_CNT_W'(MAX_LINE_CHARS)) begin
                  cmd_end = 1'b1;
               end
            end
         end
         if (cmd_end) begin
            finish_tok    = 1'b1;
            char_count_in = '0;
            idle_count_in = '0;
            nul_seen_in   = 1'b0;
         end
      end
      tok_in = finish_tok ? '0 : tok_src;
      emit   = finish_tok && (tok_src.flags != '0);
   end

   // The first key in priority order picks the target.
   always_comb begin
      priority if (tok_src.flags[0]) begin
         sel_target = TGT_SETPOINT;
      end else if (tok_src.flags[1]) begin
         sel_target = TGT_MIN;
      end else if (tok_src.flags[2]) begin
         sel_target = TGT_MAX;
      end else if (tok_src.flags[3]) begin
         sel_target = TGT_SETPOINT;
      end else if (tok_src.flags[4]) begin
         sel_target = TGT_MIN;
      end else if (tok_src.flags[5]) begin
         sel_target = TGT_MAX;
      end else begin
         sel_target = TGT_HEIGHT;
      end
   end

   // Entry into the divider, then its stages.
   always_comb begin
      pipe_in[0].target  = sel_target;
      pipe_in[0].quo     = '0;
      pipe_in[0].pow     = pow10(tok_src.frac_digits);
      if (sel_target == TGT_SETPOINT) begin
         pipe_in[0].int_val = tok_src.int_acc;
         pipe_in[0].whole   = '0;
         pipe_in[0].rem     = '0;
         pipe_in[0].neg     = 1'b0;
      end else begin
         pipe_in[0].int_val = '0;
         pipe_in[0].whole   = tok_src.whole;
         pipe_in[0].rem     = tok_src.frac;
         pipe_in[0].neg     = tok_src.neg;
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
         pipe_in[s] = div_step(pipe_ff[s-1]);
      end
   end

   // Rounding, sign and saturation into Q16.16.
   logic                  rnd;
   logic [QUO_W:0]        quo_r;
   logic [DATA_W:0]       mag;
   always_comb begin
      rnd           = {pipe_ff[DIV_STAGES].rem, 1'b0} >= {1'b0, pipe_ff[DIV_STAGES].pow};
      quo_r         = {1'b0, pipe_ff[DIV_STAGES].quo} + {{QUO_W{1'b0}}, rnd};
      mag           = {1'b0, pipe_ff[DIV_STAGES].whole, {(DATA_W-WHOLE_W){1'b0}}}
                      + {{(DATA_W-QUO_W){1'b0}}, quo_r};
      out_target_in = pipe_ff[DIV_STAGES].target;
      if (pipe_ff[DIV_STAGES].neg) begin
         if (mag >= {2'b01, {(DATA_W-1){1'b0}}}) begin
            out_real_in = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            out_real_in = DATA_W'(0) - mag[DATA_W-1:0];
         end
      end else begin
         if (mag > {2'b00, {(DATA_W-1){1'b1}}}) begin
            out_real_in = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            out_real_in = mag[DATA_W-1:0];
         end
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_fire) begin
         idle_limit_ff <= csr_ch.data;
      end
   end

   // Scan state.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         idle_count_ff <= '0;
         nul_seen_ff   <= 1'b0;
         tok_ff        <= '0;
      end else begin
         char_count_ff <= char_count_in;
         idle_count_ff <= idle_count_in;
         nul_seen_ff   <= nul_seen_in;
         tok_ff        <= tok_in;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         pv_ff        <= {pv_ff[DIV_STAGES-1:0], emit};
         out_valid_ff <= pv_ff[DIV_STAGES];
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
         out_target_ff <= out_target_in;
         out_int_ff    <= pipe_ff[DIV_STAGES].int_val;
         out_real_ff   <= out_real_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.target     = out_target_ff;
   assign rsp_ch.int_value  = out_int_ff;
   assign rsp_ch.real_value = out_real_ff;

   // Checks.
   `UKVCP_ASSERT_SAME(a_stall_holds_input, clock, reset,
      out_valid_ff && !rsp_ch.ready, !req_ch.ready, "input taken during output stall")
   `UKVCP_ASSERT_SAME(a_line_limit, clock, reset,
      1'b1, char_count_ff < CHAR_CNT_W'(MAX_LINE_CHARS), "command longer than limit")
   `UKVCP_ASSERT_NEXT(a_comma_clears, clock, reset,
      req_fire && (req_ch.kind == KIND_BYTE) && (req_ch.byte_value == CH_COMMA)
      && !nul_seen_ff, tok_ff.flags == '0, "key flags survive a comma")

endmodule
